[hw/rtl/gcc_pkg.sv]
`timescale 1ns / 1ps

package gcc_pkg;

    // genotype table: ten unordered base pairs i<=j over A,C,G,T
    localparam int NUM_GT = 10;

    // single base iupac masks; every other value is an unknown reference
    localparam logic [3:0] IUPAC_A = 4'b0001;
    localparam logic [3:0] IUPAC_C = 4'b0010;
    localparam logic [3:0] IUPAC_G = 4'b0100;
    localparam logic [3:0] IUPAC_T = 4'b1000;

    // base indexes, and the index of an unknown reference
    localparam logic [2:0] BASE_A = 3'd0;
    localparam logic [2:0] BASE_C = 3'd1;
    localparam logic [2:0] BASE_G = 3'd2;
    localparam logic [2:0] BASE_T = 3'd3;
    localparam logic [2:0] BASE_N = 3'd4;

    // extra prior for genotypes holding no reference base
    localparam logic [8:0] HET_EXTRA = 9'd3;

    // reset value of the prior register
    localparam logic [7:0] PRIOR_RESET = 8'd27;

    // quality cap
    localparam logic [7:0] QUAL_CAP = 8'd255;

    // genotype index of each reference homozygote
    localparam logic [3:0] GT_AA = 4'd0;
    localparam logic [3:0] GT_CC = 4'd4;
    localparam logic [3:0] GT_GG = 4'd7;
    localparam logic [3:0] GT_TT = 4'd9;

    // first and second base of each genotype
    localparam logic [1:0] GT_I [NUM_GT] = '{
        2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3
    };
    localparam logic [1:0] GT_J [NUM_GT] = '{
        2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3
    };

    typedef logic [9:0]  score_t;
    typedef logic [13:0] key_t;

    typedef struct packed {
        logic [3:0] ref_mask;
        logic [7:0] lk_aa;
        logic [7:0] lk_ac;
        logic [7:0] lk_ag;
        logic [7:0] lk_at;
        logic [7:0] lk_cc;
        logic [7:0] lk_cg;
        logic [7:0] lk_ct;
        logic [7:0] lk_gg;
        logic [7:0] lk_gt;
        logic [7:0] lk_tt;
        logic [7:0] rms_mapq_in;
    } site_t;

    typedef struct packed {
        logic [3:0] genotype_mask;
        logic [7:0] rms_mapq_out;
        logic [7:0] consensus_qual;
        logic [7:0] snp_qual;
    } call_t;

    // iupac mask to base index, anything but a single base is unknown
    function automatic logic [2:0] base_index(input logic [3:0] mask);
        logic [2:0] idx;
        case (mask)
            IUPAC_A: idx = BASE_A;
            IUPAC_C: idx = BASE_C;
            IUPAC_G: idx = BASE_G;
            IUPAC_T: idx = BASE_T;
            default: idx = BASE_N;
        endcase
        return idx;
    endfunction

    // score difference capped to eight bits
    function automatic logic [7:0] cap_diff(input score_t hi, input score_t lo);
        score_t d;
        d = hi - lo;
        return (d > score_t'(QUAL_CAP)) ? QUAL_CAP : d[7:0];
    endfunction

endpackage

[hw/rtl/genotype_consensus_call.sv]
`timescale 1ns / 1ps
// pipeline: one input register and one result register between site transaction and call
// throughput: one site per cycle unless the receiver stalls; the ten keys are ranked by a
//   single layer of 90 parallel comparisons between the two registers
// reset: pipeline emptied, prior register back to 27; cfg writes always taken
module genotype_consensus_call (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             site_valid,
    output logic             site_ready,
    input  gcc_pkg::site_t   site,
    output logic             call_valid,
    input  logic             call_ready,
    output gcc_pkg::call_t   call,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [7:0]       cfg_data
);

    logic            s1_valid_reg;
    gcc_pkg::site_t  s1_site_reg;
    logic            out_valid_reg;
    gcc_pkg::call_t  out_call_reg;
    logic [7:0]      prior_reg;

    logic            out_load;
    logic            s1_load;

    logic [2:0]             ref_idx;
    logic [7:0]             lk    [gcc_pkg::NUM_GT];
    gcc_pkg::score_t        score [gcc_pkg::NUM_GT];
    gcc_pkg::key_t          key   [gcc_pkg::NUM_GT];
    logic [3:0]             rank  [gcc_pkg::NUM_GT];
    logic [gcc_pkg::NUM_GT-1:0] less [gcc_pkg::NUM_GT];
    logic [8:0]             prior_full;
    gcc_pkg::key_t          best_key;
    gcc_pkg::key_t          second_key;
    gcc_pkg::key_t          worst_key;
    gcc_pkg::key_t          ref_key;
    gcc_pkg::call_t         call_next;

    // handshake: result register empties or is taken, input register follows
    assign out_load   = !out_valid_reg || call_ready;
    assign s1_load    = !s1_valid_reg || out_load;
    assign site_ready = s1_load;
    assign cfg_ready  = 1'b1;
    assign call_valid = out_valid_reg;
    assign call       = out_call_reg;

    // unpack likelihoods in genotype order
    always_comb
    begin
        lk[0] = s1_site_reg.lk_aa;
        lk[1] = s1_site_reg.lk_ac;
        lk[2] = s1_site_reg.lk_ag;
        lk[3] = s1_site_reg.lk_at;
        lk[4] = s1_site_reg.lk_cc;
        lk[5] = s1_site_reg.lk_cg;
        lk[6] = s1_site_reg.lk_ct;
        lk[7] = s1_site_reg.lk_gg;
        lk[8] = s1_site_reg.lk_gt;
        lk[9] = s1_site_reg.lk_tt;
    end

    // add priors and build keys of score and genotype code
    always_comb
    begin
        ref_idx    = gcc_pkg::base_index(s1_site_reg.ref_mask);
        prior_full = {1'b0, prior_reg} + gcc_pkg::HET_EXTRA;
        for (int g = 0; g < gcc_pkg::NUM_GT; g++)
        begin
            logic hit_i;
            logic hit_j;
            hit_i = ({1'b0, gcc_pkg::GT_I[g]} == ref_idx);
            hit_j = ({1'b0, gcc_pkg::GT_J[g]} == ref_idx);
            if (hit_i && hit_j)
                score[g] = {2'b00, lk[g]};
            else if (hit_i || hit_j)
                score[g] = {2'b00, lk[g]} + {2'b00, prior_reg};
            else
                score[g] = {2'b00, lk[g]} + {1'b0, prior_full};
            key[g] = {score[g], gcc_pkg::GT_I[g], gcc_pkg::GT_J[g]};
        end
    end

    // rank every key by counting the smaller ones; keys are distinct
    always_comb
    begin
        for (int g = 0; g < gcc_pkg::NUM_GT; g++)
        begin
            for (int k = 0; k < gcc_pkg::NUM_GT; k++)
                less[g][k] = (k != g) && (key[k] < key[g]);
            rank[g] = 4'($countones(less[g]));
        end
    end

    // pick best, second and worst by rank
    always_comb
    begin
        best_key   = '0;
        second_key = '0;
        worst_key  = '0;
        for (int g = 0; g < gcc_pkg::NUM_GT; g++)
        begin
            if (rank[g] == 4'd0)
                best_key = best_key | key[g];
            if (rank[g] == 4'd1)
                second_key = second_key | key[g];
            if (rank[g] == 4'(gcc_pkg::NUM_GT - 1))
                worst_key = worst_key | key[g];
        end
    end

    // reference homozygote, worst genotype for an unknown reference
    always_comb
    begin
        case (ref_idx)
            gcc_pkg::BASE_A: ref_key = key[gcc_pkg::GT_AA];
            gcc_pkg::BASE_C: ref_key = key[gcc_pkg::GT_CC];
            gcc_pkg::BASE_G: ref_key = key[gcc_pkg::GT_GG];
            gcc_pkg::BASE_T: ref_key = key[gcc_pkg::GT_TT];
            default:         ref_key = worst_key;
        endcase
    end

    // assemble the call
    always_comb
    begin
        call_next.genotype_mask  = (4'd1 << best_key[1:0]) | (4'd1 << best_key[3:2]);
        call_next.rms_mapq_out   = s1_site_reg.rms_mapq_in;
        call_next.consensus_qual = gcc_pkg::cap_diff(second_key[13:4], best_key[13:4]);
        call_next.snp_qual       = gcc_pkg::cap_diff(ref_key[13:4], best_key[13:4]);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prior_reg     <= gcc_pkg::PRIOR_RESET;
        end
        else
        begin
            if (s1_load)
                s1_valid_reg <= site_valid;
            if (out_load)
                out_valid_reg <= s1_valid_reg;
            if (cfg_valid)
                prior_reg <= cfg_data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s1_load && site_valid)
            s1_site_reg <= site;
        if (out_load && s1_valid_reg)
            out_call_reg <= call_next;
    end

endmodule

[hw/rtl/gcc_checker.sv]
`timescale 1ns / 1ps

module gcc_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             site_valid,
    input  logic             site_ready,
    input  logic             call_valid,
    input  logic             call_ready,
    input  gcc_pkg::call_t   call
);

    // a stalled call stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        call_valid && !call_ready |=> call_valid)
    else $error("call dropped while stalled");

    // a stalled call keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        call_valid && !call_ready |=> $stable(call))
    else $error("call payload changed while stalled");

    // an empty result side never holds off new sites
    assert property (@(posedge clk) disable iff (!rst_n)
        !call_valid |-> site_ready)
    else $error("site refused with empty result register");

    // a fresh call follows an accepted site transaction through the input and result registers
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(call_valid) |-> $past(site_valid && site_ready, 2))
    else $error("call appeared without a matching site transaction");

    // a called genotype names one or two bases
    assert property (@(posedge clk) disable iff (!rst_n)
        call_valid |-> ($countones(call.genotype_mask) == 1 ||
                        $countones(call.genotype_mask) == 2))
    else $error("genotype mask malformed");

endmodule

bind genotype_consensus_call gcc_checker u_gcc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .site_valid (site_valid),
    .site_ready (site_ready),
    .call_valid (call_valid),
    .call_ready (call_ready),
    .call       (call)
);

[sim/genotype_consensus_call_tb.sv]
`timescale 1ns / 1ps

module genotype_consensus_call_tb;

    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;

    typedef enum int {
        SHAPE_ANY,
        SHAPE_TIES,
        SHAPE_ONE_LOW,
        SHAPE_CLOSE
    } site_shape_t;

    logic            clk         = 1'b0;
    logic            rst_n       = 1'b0;
    logic            site_valid  = 1'b0;
    logic            site_ready;
    gcc_pkg::site_t  site        = '0;
    logic            call_valid;
    logic            call_ready  = 1'b0;
    gcc_pkg::call_t  call;
    logic            cfg_valid   = 1'b0;
    logic            cfg_ready;
    logic [7:0]      cfg_data    = 8'd0;

    // prior as the block should currently hold it
    logic [7:0]      prior_q_now = gcc_pkg::PRIOR_RESET;
    gcc_pkg::call_t  pending_calls [$];
    int              mismatch_count = 0;
    int              cycle_count    = 0;
    int              sender_idle_pct  = 0;
    int              receiver_stall_pct = 0;

    genotype_consensus_call dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .site_valid (site_valid),
        .site_ready (site_ready),
        .site       (site),
        .call_valid (call_valid),
        .call_ready (call_ready),
        .call       (call),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // reference index of an iupac mask, unknown for anything but one base
    function automatic logic [2:0] decode_ref(input logic [3:0] mask);
        case (mask)
            gcc_pkg::IUPAC_A: return gcc_pkg::BASE_A;
            gcc_pkg::IUPAC_C: return gcc_pkg::BASE_C;
            gcc_pkg::IUPAC_G: return gcc_pkg::BASE_G;
            gcc_pkg::IUPAC_T: return gcc_pkg::BASE_T;
            default:          return gcc_pkg::BASE_N;
        endcase
    endfunction

    function automatic logic [7:0] clip_qual(input logic [9:0] d);
        return (d > 10'(gcc_pkg::QUAL_CAP)) ? gcc_pkg::QUAL_CAP : d[7:0];
    endfunction

    // expected call for one site under a given prior
    function automatic gcc_pkg::call_t predict_call(input gcc_pkg::site_t s,
                                                    input logic [7:0] prior);
        logic [79:0]    lks;
        gcc_pkg::key_t  keys [gcc_pkg::NUM_GT];
        logic [2:0]     ref_idx;
        logic [9:0]     bump;
        gcc_pkg::key_t  best;
        gcc_pkg::key_t  second;
        gcc_pkg::key_t  worst;
        gcc_pkg::key_t  ref_key;
        int             n;
        gcc_pkg::call_t c;
        lks = {s.lk_aa, s.lk_ac, s.lk_ag, s.lk_at, s.lk_cc,
               s.lk_cg, s.lk_ct, s.lk_gg, s.lk_gt, s.lk_tt};
        ref_idx = decode_ref(s.ref_mask);
        n = 0;
        // score plus prior, genotype code in the low nibble
        for (int i = 0; i < 4; i++)
        begin
            for (int j = i; j < 4; j++)
            begin
                if (ref_idx == 3'(i) && ref_idx == 3'(j))
                    bump = 10'd0;
                else if (ref_idx == 3'(i) || ref_idx == 3'(j))
                    bump = {2'b00, prior};
                else
                    bump = {2'b00, prior} + 10'(gcc_pkg::HET_EXTRA);
                keys[n] = {10'(lks[79 - 8*n -: 8]) + bump, 2'(i), 2'(j)};
                n++;
            end
        end
        // best, worst and runner-up keys; keys never tie
        best  = keys[0];
        worst = keys[0];
        for (int k = 1; k < gcc_pkg::NUM_GT; k++)
        begin
            if (keys[k] < best)
                best = keys[k];
            if (keys[k] > worst)
                worst = keys[k];
        end
        second = '1;
        for (int k = 0; k < gcc_pkg::NUM_GT; k++)
        begin
            if (keys[k] != best && keys[k] < second)
                second = keys[k];
        end
        // reference homozygote, or the worst genotype for an unknown reference
        ref_key = worst;
        if (ref_idx != gcc_pkg::BASE_N)
        begin
            for (int k = 0; k < gcc_pkg::NUM_GT; k++)
            begin
                if (keys[k][3:0] == {ref_idx[1:0], ref_idx[1:0]})
                    ref_key = keys[k];
            end
        end
        c.genotype_mask  = (4'b0001 << best[1:0]) | (4'b0001 << best[3:2]);
        c.rms_mapq_out   = s.rms_mapq_in;
        c.consensus_qual = clip_qual(second[13:4] - best[13:4]);
        c.snp_qual       = clip_qual(ref_key[13:4] - best[13:4]);
        return c;
    endfunction

    function automatic gcc_pkg::site_t make_site(input logic [3:0] rb,
                                                 input logic [79:0] lks,
                                                 input logic [7:0] rms);
        return gcc_pkg::site_t'({rb, lks, rms});
    endfunction

    // one genotype far below all others
    function automatic gcc_pkg::site_t one_low_site(input int gt, input logic [3:0] rb,
                                                    input logic [7:0] rms);
        logic [79:0] lks;
        lks = {10{8'hff}};
        lks[79 - 8*gt -: 8] = 8'h00;
        return make_site(rb, lks, rms);
    endfunction

    function automatic gcc_pkg::site_t random_site();
        logic [79:0]  lks;
        logic [3:0]   rb;
        site_shape_t  shape;
        shape = site_shape_t'($urandom_range(3));
        case (shape)
            SHAPE_ANY:
                lks = {$urandom(), $urandom(), 16'($urandom())};
            SHAPE_TIES:
                for (int k = 0; k < gcc_pkg::NUM_GT; k++)
                    lks[8*k +: 8] = 8'($urandom_range(3));
            SHAPE_ONE_LOW:
            begin
                for (int k = 0; k < gcc_pkg::NUM_GT; k++)
                    lks[8*k +: 8] = 8'($urandom_range(255, 128));
                lks[8*$urandom_range(9) +: 8] = 8'($urandom_range(20));
            end
            default:
                for (int k = 0; k < gcc_pkg::NUM_GT; k++)
                    lks[8*k +: 8] = 8'($urandom_range(40));
        endcase
        // mostly a real base, sometimes any mask
        if ($urandom_range(3) != 0)
            rb = 4'b0001 << $urandom_range(3);
        else
            rb = 4'($urandom_range(15));
        return make_site(rb, lks, 8'($urandom_range(255)));
    endfunction

    // expectation for every accepted site transaction
    always @(posedge clk)
    begin
        if (rst_n && site_valid && site_ready)
            pending_calls.push_back(predict_call(site, prior_q_now));
    end

    // prior register shadow
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
            prior_q_now <= cfg_data;
    end

    // compare each call transaction with the oldest expectation
    always @(posedge clk)
    begin : call_check
        gcc_pkg::call_t want;
        if (rst_n && call_valid && call_ready)
        begin
            if (pending_calls.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected call at %0t: mask %h mapq %0d cons %0d snp %0d",
                             $realtime, call.genotype_mask, call.rms_mapq_out,
                             call.consensus_qual, call.snp_qual);
            end
            else
            begin
                want = pending_calls.pop_front();
                if (call.genotype_mask !== want.genotype_mask
                    || call.rms_mapq_out !== want.rms_mapq_out
                    || call.consensus_qual !== want.consensus_qual
                    || call.snp_qual !== want.snp_qual)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("call mismatch at %0t: exp %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
                                 $realtime, want.genotype_mask, want.rms_mapq_out,
                                 want.consensus_qual, want.snp_qual,
                                 call.genotype_mask, call.rms_mapq_out,
                                 call.consensus_qual, call.snp_qual);
                end
            end
        end
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        call_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // run time guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("genotype_consensus_call test failed");
            $finish;
        end
    end

    // one site transaction, entered and left at a falling edge
    task automatic send_site(input gcc_pkg::site_t s);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            site_valid = 1'b0;
            @(negedge clk);
        end
        site       = s;
        site_valid = 1'b1;
        @(posedge clk);
        while (!site_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // let every outstanding call come out
    task automatic drain_calls();
        site_valid = 1'b0;
        while (pending_calls.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_prior(input logic [7:0] value);
        drain_calls();
        cfg_data  = value;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic test_reset(input int cycles);
        rst_n = 1'b0;
        repeat (cycles) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
    endtask

    // hand-picked sites under the reset prior
    task automatic test_directed_sites();
        logic [3:0] refs [6];
        refs = '{gcc_pkg::IUPAC_A, gcc_pkg::IUPAC_C, gcc_pkg::IUPAC_G,
                 gcc_pkg::IUPAC_T, 4'h0, 4'hf};
        // all likelihoods equal: ties broken by genotype code
        for (int r = 0; r < 6; r++)
            send_site(make_site(refs[r], '0, (r % 2 == 0) ? 8'h00 : 8'hff));
        send_site(make_site(gcc_pkg::IUPAC_T, {10{8'hff}}, 8'hff));
        // every genotype as the call, reference cycling through bases and unknown
        for (int g = 0; g < gcc_pkg::NUM_GT; g++)
            send_site(one_low_site(g, (g % 5 == 4) ? 4'h6 : (4'b0001 << (g % 5)),
                                   8'(g * 25)));
        // unknown reference against a clear call
        send_site(one_low_site(int'(gcc_pkg::GT_GG), 4'h3, 8'h80));
        // alternating bit patterns
        send_site(make_site(gcc_pkg::IUPAC_C, {10{8'h55}}, 8'haa));
        send_site(make_site(gcc_pkg::IUPAC_G, {10{8'haa}}, 8'h55));
        drain_calls();
    endtask

    // prior at its extremes and near them, with caps reached
    task automatic test_prior_extremes();
        logic [7:0] priors [4];
        priors = '{8'd0, 8'd255, 8'd1, 8'd254};
        for (int p = 0; p < 4; p++)
        begin
            write_prior(priors[p]);
            for (int g = 0; g < gcc_pkg::NUM_GT; g++)
                send_site(one_low_site(g, (g % 2 == 0) ? gcc_pkg::IUPAC_A : 4'h0,
                                       8'($urandom_range(255))));
            send_site(one_low_site(int'(gcc_pkg::GT_AA), gcc_pkg::IUPAC_A, 8'h01));
            send_site(one_low_site(int'(gcc_pkg::GT_TT), gcc_pkg::IUPAC_T, 8'hfe));
            repeat (10) send_site(random_site());
        end
        drain_calls();
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input int count);
        write_prior(8'($urandom_range(255)));
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (count) send_site(random_site());
        drain_calls();
    endtask

    initial
    begin
        test_reset(4);
        test_directed_sites();
        test_prior_extremes();
        test_random_phase(0, 0, 350);
        test_random_phase(79, 0, 350);
        test_random_phase(0, 79, 350);
        test_random_phase(19, 19, 350);
        if (mismatch_count == 0)
            $display("genotype_consensus_call test passed");
        else
            $display("genotype_consensus_call test failed");
        $finish;
    end

endmodule
